### hdl/hpid_pkg.sv
// Shared types, register indexes, operation codes and fixed-point constants
// for the heading PID differential-drive controller. No dependencies.
`default_nettype none
package hpid_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP_STRAIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_STRAIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_STRAIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_TURN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_TURN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_TURN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM = 3'd7;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE = 5'd0;
	localparam op_t OP_LOAD = 5'd1;
	localparam op_t OP_WRAP = 5'd2;
	localparam op_t OP_ITP = 5'd3;
	localparam op_t OP_INT = 5'd4;
	localparam op_t OP_KP = 5'd5;
	localparam op_t OP_KD = 5'd6;
	localparam op_t OP_KI = 5'd7;
	localparam op_t OP_ADDI = 5'd8;
	localparam op_t OP_KICK = 5'd9;
	localparam op_t OP_SPIN = 5'd10;
	localparam op_t OP_LIM = 5'd11;
	localparam op_t OP_CLAMP = 5'd12;
	localparam op_t OP_LR = 5'd13;
	localparam op_t OP_BIG = 5'd14;
	localparam op_t OP_DIV = 5'd15;
	localparam op_t OP_NEXT = 5'd16;
	localparam op_t OP_PUSH = 5'd17;

	localparam int QUO_W = 9;
	localparam logic [3:0] DIV_TOP = 4'd8;

	typedef struct packed {
		op_t op;
		logic [3:0] k;
	} hpid_cmd_t;

	typedef struct packed {
		logic wrap_ok;
		logic base_zero;
		logic out_busy;
	} hpid_sts_t;

	typedef struct packed {
		logic [15:0] kp_straight;
		logic [15:0] ki_straight;
		logic [15:0] kd_straight;
		logic [15:0] kp_turn;
		logic [15:0] ki_turn;
		logic [15:0] kd_turn;
		logic [15:0] tick_period;
		logic [7:0] min_pwm;
	} hpid_cfg_t;

	localparam logic signed [18:0] HALF_TURN = 19'sd18000;
	localparam logic signed [18:0] FULL_TURN = 19'sd36000;
	localparam logic [15:0] ERR_INT_LIMIT = 16'd2000;
	localparam logic [15:0] KICK_THRESHOLD = 16'd150;
	localparam logic [8:0] KICK_EXTRA = 9'd10;
	localparam logic signed [26:0] INT_LIMIT = 27'sd1280000;
	localparam logic signed [24:0] CORR_UNIT = 25'sd6553600;
	localparam logic signed [24:0] CORR_FRACTION_UNIT = 25'sd2621440;
	localparam logic signed [45:0] SPIN_LIMIT = 46'sd720896000;
	localparam logic [32:0] PWM_MAX_CORR = 33'd1671168000;

endpackage
`default_nettype wire

### hdl/hpid_cfg.sv
// Configuration register file of the heading PID controller.
// Depends on hpid_pkg for the register indexes and the register struct.
`default_nettype none
module hpid_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [hpid_pkg::CFG_DATA_W-1:0] cfg_data,
	output hpid_pkg::hpid_cfg_t regs
);

	hpid_pkg::hpid_cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp_straight <= 16'd154;
			regs_q.ki_straight <= 16'd0;
			regs_q.kd_straight <= 16'd38;
			regs_q.kp_turn <= 16'd384;
			regs_q.ki_turn <= 16'd5;
			regs_q.kd_turn <= 16'd38;
			regs_q.tick_period <= 16'd655;
			regs_q.min_pwm <= 8'd60;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hpid_pkg::REG_KP_STRAIGHT: regs_q.kp_straight <= cfg_data;
				hpid_pkg::REG_KI_STRAIGHT: regs_q.ki_straight <= cfg_data;
				hpid_pkg::REG_KD_STRAIGHT: regs_q.kd_straight <= cfg_data;
				hpid_pkg::REG_KP_TURN: regs_q.kp_turn <= cfg_data;
				hpid_pkg::REG_KI_TURN: regs_q.ki_turn <= cfg_data;
				hpid_pkg::REG_KD_TURN: regs_q.kd_turn <= cfg_data;
				hpid_pkg::REG_TICK_PERIOD: regs_q.tick_period <= cfg_data;
				hpid_pkg::REG_MIN_PWM: regs_q.min_pwm <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/hpid_ctrl.sv
// Sequencing state machine of the heading PID controller.
// Depends on hpid_pkg for the command and status structs and operation codes.
`default_nettype none
module hpid_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire hpid_pkg::hpid_sts_t sts,
	output hpid_pkg::hpid_cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_WRAP = 5'd1;
	localparam logic [4:0] S_ITP = 5'd2;
	localparam logic [4:0] S_INT = 5'd3;
	localparam logic [4:0] S_KP = 5'd4;
	localparam logic [4:0] S_KD = 5'd5;
	localparam logic [4:0] S_KI = 5'd6;
	localparam logic [4:0] S_ADDI = 5'd7;
	localparam logic [4:0] S_KICK = 5'd8;
	localparam logic [4:0] S_SPIN = 5'd9;
	localparam logic [4:0] S_LIM = 5'd10;
	localparam logic [4:0] S_CLAMP = 5'd11;
	localparam logic [4:0] S_LR = 5'd12;
	localparam logic [4:0] S_BIG = 5'd13;
	localparam logic [4:0] S_DIVL = 5'd14;
	localparam logic [4:0] S_NEXT = 5'd15;
	localparam logic [4:0] S_DIVR = 5'd16;
	localparam logic [4:0] S_PUSH = 5'd17;

	logic [4:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd.op = hpid_pkg::OP_NONE;
		cmd.k = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = hpid_pkg::OP_LOAD;
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				cmd.op = hpid_pkg::OP_WRAP;
				if (sts.wrap_ok) state_d = S_ITP;
			end
			S_ITP: begin
				cmd.op = hpid_pkg::OP_ITP;
				state_d = S_INT;
			end
			S_INT: begin
				cmd.op = hpid_pkg::OP_INT;
				state_d = S_KP;
			end
			S_KP: begin
				cmd.op = hpid_pkg::OP_KP;
				state_d = S_KD;
			end
			S_KD: begin
				cmd.op = hpid_pkg::OP_KD;
				state_d = S_KI;
			end
			S_KI: begin
				cmd.op = hpid_pkg::OP_KI;
				state_d = S_ADDI;
			end
			S_ADDI: begin
				cmd.op = hpid_pkg::OP_ADDI;
				state_d = sts.base_zero ? S_KICK : S_LIM;
			end
			S_KICK: begin
				cmd.op = hpid_pkg::OP_KICK;
				state_d = S_SPIN;
			end
			S_SPIN: begin
				cmd.op = hpid_pkg::OP_SPIN;
				cnt_d = hpid_pkg::DIV_TOP;
				state_d = S_DIVL;
			end
			S_LIM: begin
				cmd.op = hpid_pkg::OP_LIM;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.op = hpid_pkg::OP_CLAMP;
				state_d = S_LR;
			end
			S_LR: begin
				cmd.op = hpid_pkg::OP_LR;
				state_d = S_BIG;
			end
			S_BIG: begin
				cmd.op = hpid_pkg::OP_BIG;
				cnt_d = hpid_pkg::DIV_TOP;
				state_d = S_DIVL;
			end
			S_DIVL: begin
				cmd.op = hpid_pkg::OP_DIV;
				if (cnt_q == 4'd0) state_d = S_NEXT;
				else cnt_d = cnt_q - 4'd1;
			end
			S_NEXT: begin
				cmd.op = hpid_pkg::OP_NEXT;
				cnt_d = hpid_pkg::DIV_TOP;
				state_d = S_DIVR;
			end
			S_DIVR: begin
				cmd.op = hpid_pkg::OP_DIV;
				if (cnt_q == 4'd0) state_d = S_PUSH;
				else cnt_d = cnt_q - 4'd1;
			end
			S_PUSH: begin
				if (!sts.out_busy) begin
					cmd.op = hpid_pkg::OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 4'd0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
`default_nettype wire

### hdl/hpid_dp.sv
// Datapath of the heading PID controller: shared multiplier, accumulator,
// integrators, restoring divider and output register. Depends on hpid_pkg.
`default_nettype none
module hpid_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire hpid_pkg::hpid_cmd_t cmd,
	output hpid_pkg::hpid_sts_t sts,
	input wire hpid_pkg::hpid_cfg_t regs,
	input wire logic func,
	input wire logic signed [8:0] drive_speed,
	input wire logic signed [16:0] target_heading,
	input wire logic signed [16:0] current_heading,
	input wire logic signed [17:0] gyro_rate,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [8:0] left_duty,
	output logic signed [8:0] right_duty
);

	logic sel_q;
	logic signed [8:0] base_q;
	logic signed [17:0] gyro_q;
	logic signed [18:0] wrap_q;
	logic signed [15:0] err_q;
	logic signed [23:0] acc_q;
	logic signed [23:0] store_q [2];
	logic signed [42:0] prod_q;
	logic signed [45:0] corr_q;
	logic signed [33:0] left_q, right_q;
	logic [31:0] divisor_q;
	logic [39:0] rem_q, num_r_q;
	logic [8:0] quo_q, lquo_q;
	logic neg_l_q, neg_r_q;
	logic signed [8:0] lo_q, ro_q;
	logic out_valid_q;

	logic [15:0] kp, ki, kd;
	logic signed [17:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [42:0] mul_p;
	logic [15:0] err_mag;
	logic [8:0] base_mag;
	logic signed [42:0] inc_full;
	logic signed [26:0] int_sum, int_clamped;
	logic signed [45:0] prod_ext, spin_c, spin_cl, clamp_c, neg_lim;
	logic [45:0] spin_mag;
	logic [32:0] lmag, rmag, big;
	logic [39:0] div_sh;
	logic [8:0] lo_mag, ro_mag;

	assign kp = sel_q ? regs.kp_turn : regs.kp_straight;
	assign ki = sel_q ? regs.ki_turn : regs.ki_straight;
	assign kd = sel_q ? regs.kd_turn : regs.kd_straight;
	assign err_mag = err_q[15] ? 16'(-err_q) : 16'(err_q);
	assign base_mag = base_q[8] ? 9'(-base_q) : 9'(base_q);
	assign prod_ext = 46'(prod_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			hpid_pkg::OP_ITP: begin
				mul_a = $signed({2'b00, regs.tick_period});
				mul_b = 25'(err_q);
			end
			hpid_pkg::OP_KP: begin
				mul_a = $signed({2'b00, kp});
				mul_b = 25'(err_q);
			end
			hpid_pkg::OP_KD: begin
				mul_a = $signed({2'b00, kd});
				mul_b = 25'(gyro_q);
			end
			hpid_pkg::OP_KI: begin
				mul_a = $signed({2'b00, ki});
				mul_b = 25'(acc_q);
			end
			hpid_pkg::OP_KICK: begin
				mul_a = $signed({9'd0, 9'({1'b0, regs.min_pwm}) + hpid_pkg::KICK_EXTRA});
				mul_b = hpid_pkg::CORR_UNIT;
			end
			hpid_pkg::OP_LIM: begin
				mul_a = $signed({9'd0, base_mag});
				mul_b = hpid_pkg::CORR_FRACTION_UNIT;
			end
			hpid_pkg::OP_CLAMP: begin
				mul_a = 18'(base_q);
				mul_b = hpid_pkg::CORR_UNIT;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		inc_full = (prod_q + (prod_q[42] ? 43'sd255 : 43'sd0)) >>> 8;
		int_sum = 27'(store_q[sel_q]) + 27'(inc_full);
		if (int_sum > hpid_pkg::INT_LIMIT) int_clamped = hpid_pkg::INT_LIMIT;
		else if (int_sum < -hpid_pkg::INT_LIMIT) int_clamped = -hpid_pkg::INT_LIMIT;
		else int_clamped = int_sum;
		if (err_mag >= hpid_pkg::ERR_INT_LIMIT) int_clamped = '0;
	end

	always_comb begin
		if (err_mag > hpid_pkg::KICK_THRESHOLD)
			spin_c = (err_q > 16'sd0) ? corr_q + prod_ext : corr_q - prod_ext;
		else
			spin_c = '0;
		if (spin_c > hpid_pkg::SPIN_LIMIT) spin_cl = hpid_pkg::SPIN_LIMIT;
		else if (spin_c < -hpid_pkg::SPIN_LIMIT) spin_cl = -hpid_pkg::SPIN_LIMIT;
		else spin_cl = spin_c;
		spin_mag = spin_cl[45] ? 46'(-spin_cl) : 46'(spin_cl);
	end

	always_comb begin
		neg_lim = -prod_ext;
		if (corr_q > prod_ext) clamp_c = prod_ext;
		else if (corr_q < neg_lim) clamp_c = neg_lim;
		else clamp_c = corr_q;
		lmag = left_q[33] ? 33'(-left_q) : 33'(left_q);
		rmag = right_q[33] ? 33'(-right_q) : 33'(right_q);
		big = (lmag > rmag) ? lmag : rmag;
		div_sh = {8'd0, divisor_q} << cmd.k;
		lo_mag = lquo_q;
		ro_mag = quo_q;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hpid_pkg::OP_LOAD: begin
				sel_q <= func;
				base_q <= drive_speed;
				gyro_q <= gyro_rate;
				wrap_q <= 19'(target_heading) - 19'(current_heading) + hpid_pkg::HALF_TURN;
			end
			hpid_pkg::OP_WRAP: begin
				if (wrap_q[18]) wrap_q <= wrap_q + hpid_pkg::FULL_TURN;
				else if (wrap_q >= hpid_pkg::FULL_TURN) wrap_q <= wrap_q - hpid_pkg::FULL_TURN;
				else err_q <= 16'(wrap_q - hpid_pkg::HALF_TURN);
			end
			hpid_pkg::OP_ITP, hpid_pkg::OP_KP, hpid_pkg::OP_KICK, hpid_pkg::OP_LIM: begin
				prod_q <= mul_p;
			end
			hpid_pkg::OP_INT: begin
				acc_q <= 24'(int_clamped);
			end
			hpid_pkg::OP_KD: begin
				corr_q <= prod_ext <<< 8;
				prod_q <= mul_p;
			end
			hpid_pkg::OP_KI: begin
				corr_q <= corr_q - (prod_ext <<< 8);
				prod_q <= mul_p;
			end
			hpid_pkg::OP_ADDI: begin
				corr_q <= corr_q + prod_ext;
			end
			hpid_pkg::OP_SPIN: begin
				divisor_q <= 32'(hpid_pkg::CORR_UNIT);
				rem_q <= spin_mag[39:0];
				num_r_q <= spin_mag[39:0];
				neg_l_q <= (spin_cl > 46'sd0);
				neg_r_q <= spin_cl[45];
				quo_q <= '0;
			end
			hpid_pkg::OP_CLAMP: begin
				corr_q <= clamp_c;
				prod_q <= mul_p;
			end
			hpid_pkg::OP_LR: begin
				left_q <= 34'(prod_ext - corr_q);
				right_q <= 34'(prod_ext + corr_q);
			end
			hpid_pkg::OP_BIG: begin
				if (big > hpid_pkg::PWM_MAX_CORR) begin
					divisor_q <= big[31:0];
					rem_q <= ({7'd0, lmag} << 8) - {7'd0, lmag};
					num_r_q <= ({7'd0, rmag} << 8) - {7'd0, rmag};
				end else begin
					divisor_q <= 32'(hpid_pkg::CORR_UNIT);
					rem_q <= {7'd0, lmag};
					num_r_q <= {7'd0, rmag};
				end
				neg_l_q <= left_q[33];
				neg_r_q <= right_q[33];
				quo_q <= '0;
			end
			hpid_pkg::OP_DIV: begin
				if (rem_q >= div_sh) begin
					rem_q <= rem_q - div_sh;
					quo_q <= {quo_q[7:0], 1'b1};
				end else begin
					quo_q <= {quo_q[7:0], 1'b0};
				end
			end
			hpid_pkg::OP_NEXT: begin
				lquo_q <= quo_q;
				rem_q <= num_r_q;
				quo_q <= '0;
			end
			hpid_pkg::OP_PUSH: begin
				lo_q <= neg_l_q ? -$signed(lo_mag) : $signed(lo_mag);
				ro_q <= neg_r_q ? -$signed(ro_mag) : $signed(ro_mag);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q[0] <= '0;
			store_q[1] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == hpid_pkg::OP_INT) store_q[sel_q] <= 24'(int_clamped);
			if (cmd.op == hpid_pkg::OP_PUSH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.wrap_ok = !wrap_q[18] && (wrap_q < hpid_pkg::FULL_TURN);
	assign sts.base_zero = (base_q == 9'sd0);
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign left_duty = lo_q;
	assign right_duty = ro_q;

endmodule
`default_nettype wire

### hdl/heading_pid_differential_drive.sv
// Top level of the heading PID differential-drive controller.
// Depends on hpid_pkg, hpid_cfg, hpid_ctrl and hpid_dp.
//
// Usage: an input transaction (in_valid/in_ready) carries func, drive_speed,
// target_heading, current_heading and gyro_rate. Each one produces exactly one
// output transaction (out_valid/out_ready) with left_duty and right_duty.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; the
// port is always ready and must only be used while the block is idle.
// The result follows the input transaction after the heading wrap steps, the PID
// steps through the shared 18x25 multiplier, then two nine-step restoring
// divisions for the wheel values. The sequencer works on one transaction at a
// time and passes through its idle state before it takes the next.
// The result sits in an output register, so the next input transaction is
// accepted while the previous result waits; if the receiver stalls, the block
// holds the next finished result until the output register frees.
// Reset restores the default gains and clears both integrators.
`default_nettype none
module heading_pid_differential_drive (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic func,
	input wire logic signed [8:0] drive_speed,
	input wire logic signed [16:0] target_heading,
	input wire logic signed [16:0] current_heading,
	input wire logic signed [17:0] gyro_rate,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [8:0] left_duty,
	output logic signed [8:0] right_duty,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [hpid_pkg::CFG_DATA_W-1:0] cfg_data
);

	hpid_pkg::hpid_cfg_t regs;
	hpid_pkg::hpid_cmd_t cmd;
	hpid_pkg::hpid_sts_t sts;

	hpid_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.regs(regs)
	);

	hpid_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	hpid_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.regs(regs),
		.func(func),
		.drive_speed(drive_speed),
		.target_heading(target_heading),
		.current_heading(current_heading),
		.gyro_rate(gyro_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_duty(left_duty),
		.right_duty(right_duty)
	);

endmodule
`default_nettype wire

### sim/heading_pid_differential_drive_tb.sv
// Self-checking testbench for heading_pid_differential_drive: random and directed
// heading transactions checked against an in-bench fixed-point PID predictor.
// Depends on hpid_pkg and the heading_pid_differential_drive RTL.
`default_nettype none
module heading_pid_differential_drive_tb;

	typedef struct {
		logic func;
		logic signed [8:0] base;
		logic signed [16:0] tgt;
		logic signed [16:0] cur;
		logic signed [17:0] gyro;
	} heading_item_t;

	typedef struct {
		logic signed [8:0] left;
		logic signed [8:0] right;
	} wheel_pair_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic func = 0;
	logic signed [8:0] drive_speed = 0;
	logic signed [16:0] target_heading = 0;
	logic signed [16:0] current_heading = 0;
	logic signed [17:0] gyro_rate = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [8:0] left_duty;
	logic signed [8:0] right_duty;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hpid_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	heading_pid_differential_drive dut (.*);

	heading_item_t pending_items[$];
	wheel_pair_t expected_wheels[$];
	longint gain_reg[8];
	longint integ[2];
	int errors = 0;
	bit calm = 0;
	int in_gap = 0;
	int out_gap = 0;
	// Handshake seen at the last rising edge, so the driver knows a transaction completed.
	logic in_ready_q = 0;

	initial forever #2 clk = ~clk;

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic wheel_pair_t predict_wheels(heading_item_t it);
		wheel_pair_t w;
		int sel;
		longint base, err, acc, corr, left, right, big, lo, ro, kick;
		sel = it.func;
		base = it.base;
		err = (longint'(it.tgt) - longint'(it.cur) + 18000) % 36000;
		if (err < 0) err += 36000;
		err -= 18000;
		if (absval(err) < 2000)
			acc = integ[sel] + (err * gain_reg[hpid_pkg::REG_TICK_PERIOD]) / 256;
		else acc = 0;
		acc = clamp_mag(acc, 1280000);
		integ[sel] = acc;
		corr = (gain_reg[sel*3] * err - gain_reg[sel*3+2] * longint'(it.gyro)) * 256
			+ gain_reg[sel*3+1] * acc;
		if (base == 0) begin
			if (absval(err) > 150) begin
				kick = (gain_reg[hpid_pkg::REG_MIN_PWM] + 10) * 6553600;
				corr += (err > 0) ? kick : -kick;
			end else begin
				corr = 0;
			end
			corr = clamp_mag(corr, 110 * 6553600);
			lo = -corr / 6553600;
			ro = corr / 6553600;
		end else begin
			corr = clamp_mag(corr, absval(base) * 2621440);
			left = base * 6553600 - corr;
			right = base * 6553600 + corr;
			big = absval(left) > absval(right) ? absval(left) : absval(right);
			if (big > 255 * 6553600) begin
				lo = (left * 255) / big;
				ro = (right * 255) / big;
			end else begin
				lo = left / 6553600;
				ro = right / 6553600;
			end
		end
		w.left = lo[8:0];
		w.right = ro[8:0];
		return w;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_q) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (pending_items.size() > 0) begin
					heading_item_t it;
					it = pending_items.pop_front();
					func <= it.func;
					drive_speed <= it.base;
					target_heading <= it.tgt;
					current_heading <= it.cur;
					gyro_rate <= it.gyro;
					in_valid <= 1;
					if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 9);
				end else begin
					in_valid <= 0;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				out_gap <= $urandom_range(0, 8);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		in_ready_q <= in_ready;
		if (in_valid && in_ready) expected_wheels.push_back(predict_wheels(heading_item_t'{
			func, drive_speed, target_heading, current_heading, gyro_rate}));
		if (out_valid && out_ready) begin
			if (expected_wheels.size() == 0) begin
				$error("unexpected output transaction left=%0d right=%0d", left_duty, right_duty);
				errors++;
			end else begin
				wheel_pair_t w;
				w = expected_wheels.pop_front();
				if (left_duty !== w.left) begin
					$error("left_duty expected %0d actual %0d", w.left, left_duty);
					errors++;
				end
				if (right_duty !== w.right) begin
					$error("right_duty expected %0d actual %0d", w.right, right_duty);
					errors++;
				end
			end
		end
	end

	task automatic add_item(int f, int b, int t, int c, int g);
		heading_item_t it;
		it.func = 1'(f);
		it.base = 9'(b);
		it.tgt = 17'(t);
		it.cur = 17'(c);
		it.gyro = 18'(g);
		pending_items.push_back(it);
	endtask

	task automatic add_random_items(int count);
		int k, t;
		for (k = 0; k < count; k++) begin
			t = int'($urandom_range(0, 72000)) - 36000;
			case ($urandom_range(0, 5))
				0: add_item($urandom, $urandom, $urandom, $urandom, $urandom);
				1: add_item($urandom, 0, t, t + $urandom_range(0, 600) - 300,
					$urandom_range(0, 4000) - 2000);
				2: add_item($urandom, $urandom_range(0, 510) - 255, t,
					t + $urandom_range(0, 4400) - 2200, $urandom_range(0, 20000) - 10000);
				default: add_item($urandom, $urandom_range(0, 510) - 255, t,
					int'($urandom_range(0, 72000)) - 36000,
					int'($urandom_range(0, 200000)) - 100000);
			endcase
		end
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid && expected_wheels.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [hpid_pkg::CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= hpid_pkg::CFG_DATA_W'(val);
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		gain_reg[idx] = (idx == hpid_pkg::REG_MIN_PWM) ? longint'(val & 255)
			: longint'(val & 65535);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic write_all(int kp0, int ki0, int kd0, int kp1, int ki1, int kd1,
		int dt, int mp);
		write_reg(hpid_pkg::REG_KP_STRAIGHT, kp0);
		write_reg(hpid_pkg::REG_KI_STRAIGHT, ki0);
		write_reg(hpid_pkg::REG_KD_STRAIGHT, kd0);
		write_reg(hpid_pkg::REG_KP_TURN, kp1);
		write_reg(hpid_pkg::REG_KI_TURN, ki1);
		write_reg(hpid_pkg::REG_KD_TURN, kd1);
		write_reg(hpid_pkg::REG_TICK_PERIOD, dt);
		write_reg(hpid_pkg::REG_MIN_PWM, mp);
	endtask

	initial begin
		gain_reg = '{154, 0, 38, 384, 5, 38, 655, 60};
		integ = '{0, 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		add_item(0, 0, 0, 0, 0);
		add_item(1, 0, 200, 0, 0);
		add_item(0, 0, -200, 0, 0);
		add_item(1, 0, 100, 0, 50);
		add_item(0, 255, 36000, -36000, 131071);
		add_item(1, -255, -36000, 36000, -131072);
		add_item(0, -256, 18000, 0, 0);
		add_item(1, 255, 65535, -65536, 0);
		add_item(0, 100, 1999, 0, -100000);
		add_item(1, -100, -1999, 0, 100000);
		add_item(0, 1, 2000, 0, 0);
		add_item(1, 0, -17999, 0, 0);
		add_item(0, 255, 500, 0, 0);
		add_item(0, 255, 500, 0, 0);
		add_item(1, -1, -65536, 65535, 0);
		add_item(0, 0, 150, 0, 0);
		add_item(1, 0, 151, 0, 0);
		drain();
		write_all(65535, 65535, 65535, 65535, 65535, 65535, 65535, 255);
		add_random_items(250);
		drain();
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		add_random_items(100);
		drain();
		write_all($urandom_range(0, 2000), $urandom_range(0, 300), $urandom_range(0, 300),
			$urandom_range(0, 2000), $urandom_range(0, 300), $urandom_range(0, 300),
			$urandom_range(0, 65535), $urandom_range(0, 255));
		add_random_items(250);
		drain();
		write_all(154, 0, 38, 384, 5, 38, 655, 60);
		calm = 1;
		add_random_items(250);
		drain();
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

### heading_pid_differential_drive.f
hdl/hpid_pkg.sv
hdl/hpid_cfg.sv
hdl/hpid_ctrl.sv
hdl/hpid_dp.sv
hdl/heading_pid_differential_drive.sv
sim/heading_pid_differential_drive_tb.sv
